// ===== rtl/core/uscd_pkg.sv =====
`timescale 1ns / 1ps

package uscd_pkg;

  localparam int EpochYear = 1970;
  localparam int SecsPerDay = 86400;
  localparam int SecsPerHour = 3600;
  localparam int SecsPerMin = 60;
  localparam int DaysPerWeek = 7;
  localparam int EpochWeekday = 4;
  localparam int DaysInYear = 365;
  localparam int DaysInLeapYear = 366;
  localparam logic [3:0] MonthFeb = 4'd1;
  localparam logic [3:0] MonthDec = 4'd11;

  // Scaled reciprocals of 675, 225, 15 and 7, taken once the power-of-two factor of
  // each divisor has been shifted out, for shifts of 35, 21, 14 and 18 bits.
  localparam logic [25:0] DayRecip = 26'd50903317;
  localparam logic [25:0] HourRecip = 26'd9321;
  localparam logic [25:0] MinRecip = 26'd1093;
  localparam logic [25:0] WeekRecip = 26'd37450;

  typedef struct packed {
    logic        ge;
    logic [31:0] diff;
  } step_res_t;

  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] d;
    unique case (m)
      4'd1:                      d = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/uscd_step.sv =====
`timescale 1ns / 1ps

module uscd_step
  import uscd_pkg::*;
(
  input  logic [31:0] acc,
  input  logic [31:0] operand,
  output step_res_t   res
);

  logic [32:0] wide;

  assign wide = {1'b0, acc} - {1'b0, operand};
  assign res.ge = ~wide[32];
  assign res.diff = wide[31:0];

endmodule

// ===== rtl/core/unix_seconds_to_calendar_date.sv =====
`timescale 1ns / 1ps
// After a beat is accepted, the block divides out the days, hours, minutes and weekday,
// then counts off the years from 1970 and the months from January, and raises done.
// One multiplier and one compare-and-subtract unit serve every step, so a new beat is
// taken at the earliest at the edge that ends the done cycle; busy is high from the
// accepting edge until done rises. The result is shown with done for one cycle only.
// Synchronous reset sets the block idle and the time zone offset to zero.

module unix_seconds_to_calendar_date
  import uscd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] epoch_seconds,
  input  logic               cfg_write,
  input  logic signed [4:0]  cfg_data,
  output logic               done,
  output logic [5:0]         second_of_minute,
  output logic [5:0]         minute_of_hour,
  output logic [4:0]         hour_of_day,
  output logic [2:0]         day_of_week,
  output logic [10:0]        calendar_year,
  output logic [3:0]         month_of_year,
  output logic [4:0]         day_of_month
);

  typedef enum logic [3:0] {
    S_IDLE, S_DAY, S_DAY_REM, S_HOUR, S_HOUR_REM, S_MIN, S_MIN_REM,
    S_WDAY, S_WDAY_REM, S_YEAR, S_MONTH
  } state_t;

  state_t              state;
  logic signed [4:0]   zone_offset;
  logic [31:0]         acc;
  logic [14:0]         days;
  logic [14:0]         quot;
  logic [3:0]          month;
  logic [24:0]         mul_a;
  logic [25:0]         mul_b;
  logic [50:0]         product;
  logic [31:0]         operand;
  logic                leap;
  logic                month_step;
  logic signed [33:0]  offset_secs;
  logic signed [33:0]  local_sum;
  step_res_t           res;

  // Every year in range lies between 1901 and 2099, where the rule of four is exact.
  assign leap = (calendar_year[1:0] == 2'b00);

  assign offset_secs = 34'(zone_offset) * 34'sd3600;
  assign local_sum = 34'(epoch_seconds) + offset_secs;
  assign busy = (state != S_IDLE);
  assign month_step = res.ge && (month != MonthDec);
  assign product = {26'b0, mul_a} * {25'b0, mul_b};

  always_comb begin
    unique case (state)
      S_DAY: begin
        mul_a = acc[31:7];
        mul_b = DayRecip;
      end
      S_DAY_REM: begin
        mul_a = {10'b0, days};
        mul_b = 26'(SecsPerDay);
      end
      S_HOUR: begin
        mul_a = {12'b0, acc[16:4]};
        mul_b = HourRecip;
      end
      S_HOUR_REM: begin
        mul_a = {20'b0, hour_of_day};
        mul_b = 26'(SecsPerHour);
      end
      S_MIN: begin
        mul_a = {15'b0, acc[11:2]};
        mul_b = MinRecip;
      end
      S_MIN_REM: begin
        mul_a = {19'b0, minute_of_hour};
        mul_b = 26'(SecsPerMin);
      end
      S_WDAY: begin
        mul_a = {10'b0, acc[14:0]};
        mul_b = WeekRecip;
      end
      S_WDAY_REM: begin
        mul_a = {10'b0, quot};
        mul_b = 26'(DaysPerWeek);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    unique case (state)
      S_DAY_REM, S_HOUR_REM, S_MIN_REM, S_WDAY_REM: operand = product[31:0];
      S_YEAR:  operand = leap ? 32'(DaysInLeapYear) : 32'(DaysInYear);
      S_MONTH: operand = {27'b0, month_days(month)} +
                         {31'b0, (month == MonthFeb) && leap};
      default: operand = '0;
    endcase
  end

  uscd_step u_step (
    .acc     (acc),
    .operand (operand),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      zone_offset <= '0;
    end else begin
      done <= (state == S_MONTH) && !month_step;
      if (cfg_write) begin
        zone_offset <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            acc <= local_sum[33] ? 32'd0 : local_sum[31:0];
            state <= S_DAY;
          end
        end
        S_DAY: begin
          days <= product[49:35];
          state <= S_DAY_REM;
        end
        S_DAY_REM: begin
          acc <= res.diff;
          state <= S_HOUR;
        end
        S_HOUR: begin
          hour_of_day <= product[25:21];
          state <= S_HOUR_REM;
        end
        S_HOUR_REM: begin
          acc <= res.diff;
          state <= S_MIN;
        end
        S_MIN: begin
          minute_of_hour <= product[19:14];
          state <= S_MIN_REM;
        end
        S_MIN_REM: begin
          second_of_minute <= res.diff[5:0];
          acc <= {17'b0, days} + 32'(EpochWeekday);
          state <= S_WDAY;
        end
        S_WDAY: begin
          quot <= product[32:18];
          state <= S_WDAY_REM;
        end
        S_WDAY_REM: begin
          day_of_week <= res.diff[2:0];
          acc <= {17'b0, days};
          calendar_year <= 11'(EpochYear);
          state <= S_YEAR;
        end
        S_YEAR: begin
          if (res.ge) begin
            acc <= res.diff;
            calendar_year <= calendar_year + 11'd1;
          end else begin
            month <= '0;
            state <= S_MONTH;
          end
        end
        S_MONTH: begin
          if (month_step) begin
            acc <= res.diff;
            month <= month + 4'd1;
          end else begin
            month_of_year <= month + 4'd1;
            day_of_month <= acc[4:0] + 5'd1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/uscd_checker.sv =====
`timescale 1ns / 1ps

module uscd_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [5:0]  second_of_minute,
  input logic [5:0]  minute_of_hour,
  input logic [4:0]  hour_of_day,
  input logic [2:0]  day_of_week,
  input logic [10:0] calendar_year,
  input logic [3:0]  month_of_year,
  input logic [4:0]  day_of_month
);

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done shown while still busy");

  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    done |-> second_of_minute < 6'd60 && minute_of_hour < 6'd60 &&
             hour_of_day < 5'd24 && day_of_week < 3'd7)
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    done |-> calendar_year >= 11'd1970 && calendar_year <= 11'd2038 &&
             month_of_year >= 4'd1 && month_of_year <= 4'd12 &&
             day_of_month >= 5'd1 && day_of_month <= 5'd31)
    else $error("date out of range");

endmodule

bind unix_seconds_to_calendar_date uscd_checker u_uscd_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .done             (done),
  .second_of_minute (second_of_minute),
  .minute_of_hour   (minute_of_hour),
  .hour_of_day      (hour_of_day),
  .day_of_week      (day_of_week),
  .calendar_year    (calendar_year),
  .month_of_year    (month_of_year),
  .day_of_month     (day_of_month)
);

// ===== tb/sv/calendar_date_checker.sv =====
`timescale 1ns / 1ps

module calendar_date_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] epoch_seconds,
  input  logic               cfg_write,
  input  logic signed [4:0]  cfg_data,
  input  logic               done,
  input  logic [5:0]         second_of_minute,
  input  logic [5:0]         minute_of_hour,
  input  logic [4:0]         hour_of_day,
  input  logic [2:0]         day_of_week,
  input  logic [10:0]        calendar_year,
  input  logic [3:0]         month_of_year,
  input  logic [4:0]         day_of_month,
  output int                 mismatches,
  output int                 pending
);

  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [2:0]  wday;
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
  } civil_time_t;

  civil_time_t       expected_dates[$];
  logic signed [4:0] zone_hours = '0;
  int                error_count = 0;

  function automatic bit gregorian_leap(input int y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int month_length(input int m, input int y);
    int d;
    case (m)
      1:          d = gregorian_leap(y) ? 29 : 28;
      3, 5, 8, 10: d = 30;
      default:    d = 31;
    endcase
    return d;
  endfunction

  function automatic civil_time_t to_local_date(input logic signed [4:0] zone,
                                                input logic signed [31:0] ts);
    longint      total;
    longint      days;
    int          yr;
    int          mon;
    civil_time_t r;
    total = longint'(ts) + longint'(zone) * 3600;
    if (total < 0) total = 0;
    r.sec = 6'(total % 60);
    total = total / 60;
    r.min = 6'(total % 60);
    total = total / 60;
    r.hour = 5'(total % 24);
    days = total / 24;
    r.wday = 3'((days + 4) % 7);
    yr = 1970;
    while (days >= (gregorian_leap(yr) ? 366 : 365)) begin
      days = days - (gregorian_leap(yr) ? 366 : 365);
      yr++;
    end
    mon = 0;
    while (mon < 11 && days >= month_length(mon, yr)) begin
      days = days - month_length(mon, yr);
      mon++;
    end
    r.year = 11'(yr);
    r.month = 4'(mon + 1);
    r.mday = 5'(days + 1);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < 100) $display("%0t ns: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk) begin : watch_channels
    civil_time_t want;
    if (rst) begin
      zone_hours = '0;
      expected_dates.delete();
    end else begin
      if (done) begin
        if (expected_dates.size() == 0) begin
          report_mismatch("result beat arrived with no conversion pending");
        end else begin
          want = expected_dates.pop_front();
          if (second_of_minute !== want.sec)
            report_mismatch($sformatf("second_of_minute got %0d expected %0d",
                                      second_of_minute, want.sec));
          if (minute_of_hour !== want.min)
            report_mismatch($sformatf("minute_of_hour got %0d expected %0d",
                                      minute_of_hour, want.min));
          if (hour_of_day !== want.hour)
            report_mismatch($sformatf("hour_of_day got %0d expected %0d",
                                      hour_of_day, want.hour));
          if (day_of_week !== want.wday)
            report_mismatch($sformatf("day_of_week got %0d expected %0d",
                                      day_of_week, want.wday));
          if (calendar_year !== want.year)
            report_mismatch($sformatf("calendar_year got %0d expected %0d",
                                      calendar_year, want.year));
          if (month_of_year !== want.month)
            report_mismatch($sformatf("month_of_year got %0d expected %0d",
                                      month_of_year, want.month));
          if (day_of_month !== want.mday)
            report_mismatch($sformatf("day_of_month got %0d expected %0d",
                                      day_of_month, want.mday));
        end
      end
      if (start && !busy) expected_dates.push_back(to_local_date(zone_hours, epoch_seconds));
      if (cfg_write) zone_hours = cfg_data;
    end
    pending <= expected_dates.size();
    mismatches <= error_count;
  end

endmodule

// ===== tb/sv/unix_seconds_to_calendar_date_tb.sv =====
`timescale 1ns / 1ps

module unix_seconds_to_calendar_date_tb;

  localparam int StallLimit = 4000;
  localparam int DrainCycles = 130;
  localparam int RandomPhases = 8;
  localparam int ItemsPerPhase = 180;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] epoch_seconds = '0;
  logic               cfg_write = 1'b0;
  logic signed [4:0]  cfg_data = '0;
  logic               done;
  logic [5:0]         second_of_minute;
  logic [5:0]         minute_of_hour;
  logic [4:0]         hour_of_day;
  logic [2:0]         day_of_week;
  logic [10:0]        calendar_year;
  logic [3:0]         month_of_year;
  logic [4:0]         day_of_month;
  int                 mismatches;
  int                 outstanding;
  int                 stall_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  unix_seconds_to_calendar_date u_top (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .epoch_seconds    (epoch_seconds),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .done             (done),
    .second_of_minute (second_of_minute),
    .minute_of_hour   (minute_of_hour),
    .hour_of_day      (hour_of_day),
    .day_of_week      (day_of_week),
    .calendar_year    (calendar_year),
    .month_of_year    (month_of_year),
    .day_of_month     (day_of_month)
  );

  calendar_date_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .epoch_seconds    (epoch_seconds),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .done             (done),
    .second_of_minute (second_of_minute),
    .minute_of_hour   (minute_of_hour),
    .hour_of_day      (hour_of_day),
    .day_of_week      (day_of_week),
    .calendar_year    (calendar_year),
    .month_of_year    (month_of_year),
    .day_of_month     (day_of_month),
    .mismatches       (mismatches),
    .pending          (outstanding)
  );

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_timestamp(input logic signed [31:0] ts, input bit steady);
    int gap;
    int k;
    start <= 1'b1;
    epoch_seconds <= ts;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = 0;
    if (!steady) begin
      k = $urandom_range(0, 15);
      if (k >= 14) gap = $urandom_range(20, 80);
      else if (k >= 6) gap = $urandom_range(1, 4);
    end
    if (gap > 0) begin
      start <= 1'b0;
      epoch_seconds <= $urandom();
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_zone(input logic signed [4:0] zone);
    cfg_write <= 1'b1;
    cfg_data <= zone;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int                 p;
    int                 n;
    int                 kind;
    logic signed [31:0] ts;
    logic signed [4:0]  zone;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_timestamp(32'sd0, 1'b0);
    send_timestamp(32'sd1, 1'b0);
    send_timestamp(32'sd59, 1'b0);
    send_timestamp(32'sd60, 1'b0);
    send_timestamp(32'sd3599, 1'b0);
    send_timestamp(32'sd3600, 1'b0);
    send_timestamp(32'sd86399, 1'b0);
    send_timestamp(32'sd86400, 1'b0);
    send_timestamp(-32'sd1, 1'b0);
    send_timestamp(32'h8000_0000, 1'b0);
    send_timestamp(32'h7fff_ffff, 1'b0);
    send_timestamp(32'sd68169599, 1'b0);
    send_timestamp(32'sd68169600, 1'b0);
    send_timestamp(32'sd94694399, 1'b0);
    send_timestamp(32'sd94694400, 1'b0);
    send_timestamp(32'sd951782400, 1'b0);
    send_timestamp(32'sd978307199, 1'b0);
    send_timestamp(32'sd1709164800, 1'b0);

    wait_idle();
    write_zone(5'sd15);
    send_timestamp(32'h7fff_ffff, 1'b0);
    send_timestamp(32'sd0, 1'b0);

    wait_idle();
    write_zone(-5'sd16);
    send_timestamp(32'sd57599, 1'b0);
    send_timestamp(32'sd57600, 1'b0);
    send_timestamp(32'sd57601, 1'b0);

    for (p = 0; p < RandomPhases; p++) begin
      case (p)
        0:       zone = -5'sd12;
        1:       zone = 5'sd14;
        2:       zone = -5'sd16;
        3:       zone = 5'sd15;
        4:       zone = -5'sd1;
        5:       zone = 5'sd0;
        default: zone = 5'($urandom_range(0, 31));
      endcase
      wait_idle();
      write_zone(zone);
      for (n = 0; n < ItemsPerPhase; n++) begin
        kind = $urandom_range(0, 9);
        case (kind)
          0, 1, 2, 3: ts = $urandom() & 32'h7fff_ffff;
          4, 5:       ts = $urandom();
          6:          ts = $urandom_range(0, 200000) - 100000;
          7:          ts = 32'h7fff_ffff - $urandom_range(0, 200000);
          default:    ts = $urandom_range(0, 24855) * 86400 + $urandom_range(0, 20) - 10;
        endcase
        send_timestamp(ts, (p % 3) == 2);
      end
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
